// ===== hdl/aepq_pkg.sv =====
// Shared types and constants for the active/expired priority run queue.
// Depends on nothing; every other file but aepq_ram takes names from here by scope.
package aepq_pkg;

    // Sizing of the queue set
    localparam int MAX_LEVELS  = 8;
    localparam int LEVEL_DEPTH = 16;
    localparam int ID_BITS     = 8;
    localparam int NUM_QUEUES  = 2 * MAX_LEVELS;
    localparam int STORE_SIZE  = NUM_QUEUES * LEVEL_DEPTH;

    // Derived widths
    localparam int LVL_W  = $clog2(MAX_LEVELS);
    localparam int Q_W    = LVL_W + 1;
    localparam int PTR_W  = $clog2(LEVEL_DEPTH);
    localparam int CNT_W  = $clog2(LEVEL_DEPTH + 1);
    localparam int ADDR_W = Q_W + PTR_W;

    // Field widths of the item and result channels
    localparam int TASK_W   = 8;
    localparam int PRIO_W   = 4;
    localparam int STATUS_W = 3;
    localparam int OLVL_W   = 3;
    localparam int CFG_W    = 4;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [CFG_W-1:0] LEVELS_RESET = 4'd4;
    localparam logic REG_LEVELS_IN_USE = 1'b0;   // register index, from paddr[2]

    // Item action codes
    localparam logic ACT_INS = 1'b0;
    localparam logic ACT_DEQ = 1'b1;

    // Dynamic priority that marks an expired quantum
    localparam logic signed [PRIO_W-1:0] PRIO_EXPIRED = -4'sd1;

    typedef enum logic [STATUS_W-1:0] {
        ST_INS_ACTIVE  = 3'd0,
        ST_INS_EXPIRED = 3'd1,
        ST_DEQUEUED    = 3'd2,
        ST_EMPTY       = 3'd3,
        ST_FULL        = 3'd4,
        ST_BAD_PRIO    = 3'd5
    } t_status;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;    // latch the accepted item
        logic execute;    // update the queue state and issue the store access
        logic load_out;   // move the result into the output register
    } t_cmd;

endpackage

// ===== hdl/aepq_if.sv =====
// Item and result channel interfaces for the priority run queue.
// Depends on aepq_pkg for field widths.
interface aepq_in_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   action;
    logic [aepq_pkg::TASK_W-1:0]            task_id;
    logic signed [aepq_pkg::PRIO_W-1:0]     dyn_prio;
    logic [aepq_pkg::PRIO_W-1:0]            static_prio;

    modport source (output valid, action, task_id, dyn_prio, static_prio, input ready);
    modport sink   (input valid, action, task_id, dyn_prio, static_prio, output ready);
endinterface

interface aepq_out_if;
    logic                              valid;
    logic                              ready;
    logic [aepq_pkg::STATUS_W-1:0]     status;
    logic [aepq_pkg::TASK_W-1:0]       out_task_id;
    logic [aepq_pkg::OLVL_W-1:0]       out_level;
    logic                              banks_swapped;
    logic [aepq_pkg::OLVL_W-1:0]       new_dyn_prio;

    modport source (output valid, status, out_task_id, out_level, banks_swapped,
                    new_dyn_prio, input ready);
    modport sink   (input valid, status, out_task_id, out_level, banks_swapped,
                    new_dyn_prio, output ready);
endinterface

// ===== hdl/active_expired_priority_queue.sv =====
// Active/expired multilevel priority run queue: one result per item.
// The item is captured, the execute step updates the queue state and reads the id
// store, and the finish step loads the output register. A new item is taken only
// when idle or as the last result leaves; a stalled result holds further items off.
// Reset (synchronous, active low): FIFO counts and heads clear, bank 0 active,
// levels_in_use returns to 4; the id store is not cleared.
module active_expired_priority_queue (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    aepq_in_if.sink                            i_item,
    aepq_out_if.source                         o_result,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [aepq_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [aepq_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [aepq_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready
);
    aepq_pkg::t_cmd             cmd;
    logic [aepq_pkg::CFG_W-1:0] r_levels;
    logic                       sel_levels;

    // Configuration register
    assign pready     = 1'b1;
    assign sel_levels = (paddr[2] == aepq_pkg::REG_LEVELS_IN_USE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_levels <= aepq_pkg::LEVELS_RESET;
        end else if (psel && penable && pwrite && sel_levels) begin
            r_levels <= pwdata[aepq_pkg::CFG_W-1:0];
        end
    end

    assign prdata = sel_levels ? aepq_pkg::APB_DATA_W'(r_levels) : '0;

    aepq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .o_in_ready  (i_item.ready),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .o_cmd       (cmd)
    );

    aepq_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_levels        (r_levels),
        .i_action        (i_item.action),
        .i_task_id       (i_item.task_id),
        .i_dyn_prio      (i_item.dyn_prio),
        .i_static_prio   (i_item.static_prio),
        .o_status        (o_result.status),
        .o_out_task_id   (o_result.out_task_id),
        .o_out_level     (o_result.out_level),
        .o_banks_swapped (o_result.banks_swapped),
        .o_new_dyn_prio  (o_result.new_dyn_prio)
    );
endmodule

// ===== hdl/aepq_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module aepq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hdl/aepq_ctrl.sv =====
// Controller state machine: item handshake, sequencing and output valid.
// Depends on aepq_pkg for the command struct.
module aepq_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output aepq_pkg::t_cmd o_cmd
);
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_FIN  = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;
    logic   in_ready;
    logic   capture;

    // Output slot is free when empty or being taken this cycle
    assign out_free = !r_out_valid || i_out_ready;
    assign in_ready = (r_state == S_IDLE) || ((r_state == S_FIN) && out_free);
    assign capture  = i_in_valid && in_ready;

    // Issue commands
    always_comb begin
        o_cmd.capture  = capture;
        o_cmd.execute  = (r_state == S_EXEC);
        o_cmd.load_out = (r_state == S_FIN) && out_free;
    end

    // Advance the sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (capture) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                if (out_free) begin
                    n_state = capture ? S_EXEC : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold the result valid until taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = in_ready;
    assign o_out_valid = r_out_valid;

    // Execution is always followed by the finish step
    a_exec_to_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EXEC |=> r_state == S_FIN)
        else $error("execute step not followed by finish step");

    // A stalled result keeps the sequencer in the finish step
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && r_out_valid && !i_out_ready) |=> r_state == S_FIN)
        else $error("sequencer left finish step while result stalled");

    // Loading the output register always presents a result
    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |=> r_out_valid)
        else $error("result loaded but not presented");
endmodule

// ===== hdl/aepq_dp.sv =====
// Datapath: item register, FIFO heads and counts, id store, bank select, result.
// Depends on aepq_pkg and aepq_ram.
module aepq_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  aepq_pkg::t_cmd                      i_cmd,
    input  logic [aepq_pkg::CFG_W-1:0]          i_levels,
    input  logic                                i_action,
    input  logic [aepq_pkg::TASK_W-1:0]         i_task_id,
    input  logic signed [aepq_pkg::PRIO_W-1:0]  i_dyn_prio,
    input  logic [aepq_pkg::PRIO_W-1:0]         i_static_prio,
    output logic [aepq_pkg::STATUS_W-1:0]       o_status,
    output logic [aepq_pkg::TASK_W-1:0]         o_out_task_id,
    output logic [aepq_pkg::OLVL_W-1:0]         o_out_level,
    output logic                                o_banks_swapped,
    output logic [aepq_pkg::OLVL_W-1:0]         o_new_dyn_prio
);
    localparam int NQ = aepq_pkg::NUM_QUEUES;
    localparam int NL = aepq_pkg::MAX_LEVELS;

    // Item register
    logic                                r_action;
    logic [aepq_pkg::TASK_W-1:0]         r_task_id;
    logic signed [aepq_pkg::PRIO_W-1:0]  r_dyn_prio;
    logic [aepq_pkg::PRIO_W-1:0]         r_static_prio;

    // Queue state
    logic [aepq_pkg::CNT_W-1:0] r_count [NQ];
    logic [aepq_pkg::CNT_W-1:0] n_count [NQ];
    logic [aepq_pkg::PTR_W-1:0] r_head  [NQ];
    logic [aepq_pkg::PTR_W-1:0] n_head  [NQ];
    logic                       r_act_bank, n_act_bank;

    // Pending result, between execute and output load
    aepq_pkg::t_status          r_res_status, n_res_status;
    logic [aepq_pkg::LVL_W-1:0] r_res_level, n_res_level;
    logic                       r_res_swapped, n_res_swapped;
    logic [aepq_pkg::LVL_W-1:0] r_res_newp, n_res_newp;

    // Output register
    logic [aepq_pkg::STATUS_W-1:0] r_out_status;
    logic [aepq_pkg::TASK_W-1:0]   r_out_id;
    logic [aepq_pkg::OLVL_W-1:0]   r_out_level;
    logic                          r_out_swapped;
    logic [aepq_pkg::OLVL_W-1:0]   r_out_newp;

    // Working signals
    logic [aepq_pkg::CFG_W-1:0]   levels_eff;
    logic                         expired;
    logic signed [aepq_pkg::PRIO_W:0] target;
    logic                         bad_prio;
    logic [aepq_pkg::LVL_W-1:0]   ins_lvl;
    logic [aepq_pkg::Q_W-1:0]     ins_q;
    logic                         ins_full;
    logic [aepq_pkg::PTR_W-1:0]   ins_tail;
    logic [NL-1:0]                ne_act, ne_exp, ne_sel;
    logic                         any_act, found;
    logic                         deq_bank;
    logic [aepq_pkg::LVL_W-1:0]   deq_lvl;
    logic [aepq_pkg::Q_W-1:0]     deq_q;
    logic                         ram_we, ram_re;
    logic [aepq_pkg::ADDR_W-1:0]  ram_waddr, ram_raddr;
    logic [aepq_pkg::ID_BITS-1:0] ram_rdata;

    // Latch the accepted item
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_action      <= i_action;
            r_task_id     <= i_task_id;
            r_dyn_prio    <= i_dyn_prio;
            r_static_prio <= i_static_prio;
        end
    end

    // Clamp the level count to the levels built
    assign levels_eff = (i_levels > aepq_pkg::CFG_W'(NL)) ? aepq_pkg::CFG_W'(NL) : i_levels;

    // Insert: pick target level and bank, check range and room
    assign expired  = (r_dyn_prio == aepq_pkg::PRIO_EXPIRED);
    assign target   = expired ? ($signed({1'b0, r_static_prio}) - 5'sd1)
                              : {r_dyn_prio[aepq_pkg::PRIO_W-1], r_dyn_prio};
    assign bad_prio = target[aepq_pkg::PRIO_W] ||
                      (target[aepq_pkg::PRIO_W-1:0] >= levels_eff);
    assign ins_lvl  = target[aepq_pkg::LVL_W-1:0];
    assign ins_q    = {r_act_bank ^ expired, ins_lvl};
    assign ins_full = (r_count[ins_q] >= aepq_pkg::CNT_W'(aepq_pkg::LEVEL_DEPTH));
    assign ins_tail = r_head[ins_q] + r_count[ins_q][aepq_pkg::PTR_W-1:0];

    // Dequeue: non-empty maps of both banks over the levels in use
    always_comb begin
        for (int l = 0; l < NL; l++) begin
            ne_act[l] = (aepq_pkg::CFG_W'(l) < levels_eff) &&
                        (r_count[{r_act_bank, aepq_pkg::LVL_W'(l)}] != '0);
            ne_exp[l] = (aepq_pkg::CFG_W'(l) < levels_eff) &&
                        (r_count[{~r_act_bank, aepq_pkg::LVL_W'(l)}] != '0);
        end
    end

    assign any_act  = |ne_act;
    assign deq_bank = any_act ? r_act_bank : ~r_act_bank;
    assign ne_sel   = any_act ? ne_act : ne_exp;
    assign found    = |ne_sel;

    // Highest set level wins
    always_comb begin
        deq_lvl = '0;
        for (int l = 0; l < NL; l++) begin
            if (ne_sel[l]) begin
                deq_lvl = aepq_pkg::LVL_W'(l);
            end
        end
    end

    assign deq_q = {deq_bank, deq_lvl};

    // Update heads, counts, bank select and the pending result
    always_comb begin
        n_count       = r_count;
        n_head        = r_head;
        n_act_bank    = r_act_bank;
        n_res_status  = r_res_status;
        n_res_level   = r_res_level;
        n_res_swapped = r_res_swapped;
        n_res_newp    = r_res_newp;
        ram_we        = 1'b0;
        ram_re        = 1'b0;
        ram_waddr     = {ins_q, ins_tail};
        ram_raddr     = {deq_q, r_head[deq_q]};
        if (i_cmd.execute) begin
            n_res_level   = '0;
            n_res_swapped = 1'b0;
            n_res_newp    = '0;
            if (r_action == aepq_pkg::ACT_DEQ) begin
                n_res_swapped = !any_act;
                if (!any_act) begin
                    n_act_bank = ~r_act_bank;
                end
                if (found) begin
                    n_res_status   = aepq_pkg::ST_DEQUEUED;
                    n_res_level    = deq_lvl;
                    n_head[deq_q]  = r_head[deq_q] + aepq_pkg::PTR_W'(1);
                    n_count[deq_q] = r_count[deq_q] - aepq_pkg::CNT_W'(1);
                    ram_re         = 1'b1;
                end else begin
                    n_res_status = aepq_pkg::ST_EMPTY;
                end
            end else if (bad_prio) begin
                n_res_status = aepq_pkg::ST_BAD_PRIO;
            end else begin
                n_res_level = ins_lvl;
                n_res_newp  = ins_lvl;
                if (ins_full) begin
                    n_res_status = aepq_pkg::ST_FULL;
                end else begin
                    n_count[ins_q] = r_count[ins_q] + aepq_pkg::CNT_W'(1);
                    ram_we         = 1'b1;
                    n_res_status   = expired ? aepq_pkg::ST_INS_EXPIRED
                                             : aepq_pkg::ST_INS_ACTIVE;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int q = 0; q < NQ; q++) begin
                r_count[q] <= '0;
                r_head[q]  <= '0;
            end
            r_act_bank <= 1'b0;
        end else begin
            r_count    <= n_count;
            r_head     <= n_head;
            r_act_bank <= n_act_bank;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res_status  <= n_res_status;
        r_res_level   <= n_res_level;
        r_res_swapped <= n_res_swapped;
        r_res_newp    <= n_res_newp;
    end

    // Id store
    aepq_ram #(
        .WIDTH (aepq_pkg::ID_BITS),
        .DEPTH (aepq_pkg::STORE_SIZE)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_task_id[aepq_pkg::ID_BITS-1:0]),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Load the output register; id only for a dequeue
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_status  <= r_res_status;
            r_out_id      <= (r_res_status == aepq_pkg::ST_DEQUEUED)
                             ? aepq_pkg::TASK_W'(ram_rdata) : '0;
            r_out_level   <= aepq_pkg::OLVL_W'(r_res_level);
            r_out_swapped <= r_res_swapped;
            r_out_newp    <= aepq_pkg::OLVL_W'(r_res_newp);
        end
    end

    assign o_status        = r_out_status;
    assign o_out_task_id   = r_out_id;
    assign o_out_level     = r_out_level;
    assign o_banks_swapped = r_out_swapped;
    assign o_new_dyn_prio  = r_out_newp;
endmodule
